// File: rtl/maf_pkg.sv
package maf_pkg;

   localparam int DATA_W         = 16;
   localparam int CFG_W          = 6;
   localparam int MAX_WINDOW_DEF = 32;

   localparam logic [CFG_W-1:0] WINDOW_RESET = 6'd8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_ABS,
      ST_DIV,
      ST_SIGN,
      ST_OUT
   } state_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

endpackage

// File: rtl/maf_if.sv
interface maf_req_if;
   import maf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

interface maf_rsp_if;
   import maf_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] average;

   modport source (output valid, output average, input ready);
   modport sink   (input valid, input average, output ready);
endinterface

// File: rtl/moving_average_filter.sv
// Moving average over the last L samples, L taken from the csr register
// (0 counts as 1, values above MAX_WINDOW count as MAX_WINDOW).
// req channel: one signed 16-bit sample per word, taken when valid and
// ready are both high. rsp channel: one signed 16-bit average per word,
// the window sum divided by L, truncated toward zero.
// csr port: csr_write_enable writes csr_write_data into the length
// register at the clock edge; change it only while the block is idle.
// After a sample is accepted it is summed and divided before rsp valid; the
// sum is S = 16 + clog2(MAX_WINDOW) bits wide (S = 21 for the default):
// the window is swept one entry a cycle through the store's single
// read and write port, then a restoring divider takes one quotient bit a
// cycle, all on one shared adder. req ready is high only while idle.
// The block takes no new sample until it is through with the last one.
// A finished average waits in the output register while the next sample
// is taken; if the receiver still stalls at the end of that sample, the
// block holds there until the waiting word is taken.
// Reset is synchronous: it drops rsp valid, returns the length to 8 and
// makes every window entry read as zero until written.
module moving_average_filter #(
   parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   maf_req_if.sink                   req,
   maf_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [maf_pkg::CFG_W-1:0] csr_write_data
);
   import maf_pkg::*;

   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ALU_W  = DATA_W + $clog2(MAX_WINDOW) + 1;

   logic [CFG_W-1:0]         window_length_ff;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic signed [DATA_W-1:0] wr_data;
   logic                     rd_en;
   logic [ADDR_W-1:0]        rd_addr;
   logic signed [DATA_W-1:0] rd_data;
   alu_op_type               alu_op;
   logic signed [ALU_W-1:0]  alu_a;
   logic signed [ALU_W-1:0]  alu_b;
   logic signed [ALU_W-1:0]  alu_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_RESET;
      end else if (csr_write_enable) begin
         window_length_ff <= csr_write_data;
      end
   end

   maf_seq #(.MAX_WINDOW(MAX_WINDOW)) u_seq (
      .clock         (clock),
      .reset         (reset),
      .window_length (window_length_ff),
      .req           (req),
      .rsp           (rsp),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .alu_op        (alu_op),
      .alu_a         (alu_a),
      .alu_b         (alu_b),
      .alu_y         (alu_y)
   );

   maf_store #(.MAX_WINDOW(MAX_WINDOW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   maf_alu #(.W(ALU_W)) u_alu (
      .op (alu_op),
      .a  (alu_a),
      .b  (alu_b),
      .y  (alu_y)
   );

endmodule

// File: rtl/maf_alu.sv
module maf_alu #(
   parameter int W = 17
) (
   input  maf_pkg::alu_op_type op,
   input  logic signed [W-1:0] a,
   input  logic signed [W-1:0] b,
   output logic signed [W-1:0] y
);
   import maf_pkg::*;

   always_comb begin
      case (op)
         ALU_ADD: y = a + b;
         ALU_SUB: y = a - b;
         default: y = a + b;
      endcase
   end

endmodule

// File: rtl/maf_store.sv
module maf_store #(
   parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF,
   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             wr_en,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic signed [maf_pkg::DATA_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [ADDR_W-1:0]                rd_addr,
   output logic signed [maf_pkg::DATA_W-1:0] rd_data
);
   import maf_pkg::*;

   logic signed [DATA_W-1:0] window_ff [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]    valid_ff;
   logic signed [DATA_W-1:0] rd_q_ff;
   logic                     rd_ok_ff;

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_ok_ff <= valid_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         window_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= window_ff[rd_addr];
      end
   end

   assign rd_data = rd_ok_ff ? rd_q_ff : '0;

endmodule

// File: rtl/maf_seq.sv
module maf_seq #(
   parameter int MAX_WINDOW = maf_pkg::MAX_WINDOW_DEF,
   localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
   localparam int ALU_W  = maf_pkg::DATA_W + $clog2(MAX_WINDOW) + 1
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [maf_pkg::CFG_W-1:0]          window_length,
   maf_req_if.sink                            req,
   maf_rsp_if.source                          rsp,
   output logic                              wr_en,
   output logic [ADDR_W-1:0]                 wr_addr,
   output logic signed [maf_pkg::DATA_W-1:0] wr_data,
   output logic                              rd_en,
   output logic [ADDR_W-1:0]                 rd_addr,
   input  logic signed [maf_pkg::DATA_W-1:0] rd_data,
   output maf_pkg::alu_op_type               alu_op,
   output logic signed [ALU_W-1:0]           alu_a,
   output logic signed [ALU_W-1:0]           alu_b,
   input  logic signed [ALU_W-1:0]           alu_y
);
   import maf_pkg::*;

   localparam int LEN_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = ALU_W - 1;
   localparam int CNT_W = $clog2(SUM_W + 1);
   localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;

   state_type                state_ff, state_in;
   logic [LEN_W-1:0]         k_ff, k_in;
   logic [LEN_W-1:0]         n_ff, n_in;
   logic signed [DATA_W-1:0] sample_ff, sample_in;
   logic signed [ALU_W-1:0]  acc_ff, acc_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [LEN_W-1:0]         rem_ff, rem_in;
   logic                     neg_ff, neg_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [DATA_W-1:0] res_ff, res_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_average_ff, rsp_average_in;

   logic [CMP_W-1:0]         len_raw;
   logic [LEN_W-1:0]         eff_len;
   logic                     last;
   logic [LEN_W:0]           k_ahead;
   logic [LEN_W:0]           shifted;
   logic                     out_free;

   // clamp the length register to 1..MAX_WINDOW
   always_comb begin
      len_raw = CMP_W'(window_length);
      if (len_raw == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_raw > CMP_W'(MAX_WINDOW)) begin
         eff_len = LEN_W'(MAX_WINDOW);
      end else begin
         eff_len = len_raw[LEN_W-1:0];
      end
   end

   assign last     = (k_ff == n_ff - LEN_W'(1));
   assign k_ahead  = {1'b0, k_ff} + (LEN_W + 1)'(2);
   assign shifted  = {rem_ff, quo_ff[SUM_W-1]};
   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (last) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = ST_SIGN;
            end
         end
         ST_SIGN: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = '0;
      wr_en     = 1'b0;
      wr_addr   = k_ff[ADDR_W-1:0];
      wr_data   = last ? sample_ff : rd_data;
      alu_op    = ALU_ADD;
      alu_a     = '0;
      alu_b     = '0;
      case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            rd_en     = req.valid && (eff_len > LEN_W'(1));
            rd_addr   = ADDR_W'(1);
         end
         ST_SWEEP: begin
            rd_en   = (k_ahead < {1'b0, n_ff});
            rd_addr = k_ahead[ADDR_W-1:0];
            wr_en   = 1'b1;
            alu_op  = ALU_ADD;
            alu_a   = acc_ff;
            alu_b   = ALU_W'(wr_data);
         end
         ST_ABS: begin
            alu_op = ALU_SUB;
            alu_b  = acc_ff;
         end
         ST_DIV: begin
            alu_op = ALU_SUB;
            alu_a  = ALU_W'(shifted);
            alu_b  = ALU_W'(n_ff);
         end
         ST_SIGN: begin
            alu_op = neg_ff ? ALU_SUB : ALU_ADD;
            alu_b  = ALU_W'(quo_ff);
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      k_in           = k_ff;
      n_in           = n_ff;
      sample_in      = sample_ff;
      acc_in         = acc_ff;
      quo_in         = quo_ff;
      rem_in         = rem_ff;
      neg_in         = neg_ff;
      cnt_in         = cnt_ff;
      res_in         = res_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_average_in = rsp_average_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               n_in      = eff_len;
               sample_in = req.sample;
               k_in      = '0;
               acc_in    = '0;
            end
         end
         ST_SWEEP: begin
            acc_in = alu_y;
            k_in   = k_ff + LEN_W'(1);
         end
         ST_ABS: begin
            neg_in = acc_ff[ALU_W-1];
            quo_in = acc_ff[ALU_W-1] ? alu_y[SUM_W-1:0] : acc_ff[SUM_W-1:0];
            rem_in = '0;
            cnt_in = '0;
         end
         ST_DIV: begin
            if (!alu_y[ALU_W-1]) begin
               rem_in = alu_y[LEN_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[LEN_W-1:0];
               quo_in = {quo_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
         end
         ST_SIGN: begin
            res_in = alu_y[DATA_W-1:0];
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_average_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff           <= k_in;
      n_ff           <= n_in;
      sample_ff      <= sample_in;
      acc_ff         <= acc_in;
      quo_ff         <= quo_in;
      rem_ff         <= rem_in;
      neg_ff         <= neg_in;
      cnt_ff         <= cnt_in;
      res_ff         <= res_in;
      rsp_average_ff <= rsp_average_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.average = rsp_average_ff;

endmodule

// File: rtl/maf_checker.sv
module maf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [maf_pkg::DATA_W-1:0] rsp_average
);
   import maf_pkg::*;

   // out of reset: idle, nothing offered
   a_reset_idle : assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // a taken sample keeps the block busy
   a_busy_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("ready again straight after a sample");

   // a new average only appears at the end of a busy spell
   a_result_after_work : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("average raised without work");

   // a stalled word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_average)))
      else $error("stalled average changed or dropped");

endmodule

bind moving_average_filter maf_checker u_maf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req.valid),
   .req_ready   (req.ready),
   .rsp_valid   (rsp.valid),
   .rsp_ready   (rsp.ready),
   .rsp_average (rsp.average)
);

// File: tb/maf_average_checker.sv
module maf_average_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  logic signed [maf_pkg::DATA_W-1:0] req_sample,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic signed [maf_pkg::DATA_W-1:0] rsp_average,
   input  logic                              csr_write_enable,
   input  logic [maf_pkg::CFG_W-1:0]         csr_write_data,
   output int                                mismatch_count,
   output int                                outstanding
);
   import maf_pkg::*;

   logic signed [DATA_W-1:0] window_store [MAX_WINDOW_DEF];
   logic signed [DATA_W-1:0] expected_averages [$];
   logic [CFG_W-1:0]         length_reg;
   int                       errors = 0;

   function automatic int active_length();
      int n;
      n = int'(length_reg);
      if (n == 0) n = 1;
      if (n > MAX_WINDOW_DEF) n = MAX_WINDOW_DEF;
      return n;
   endfunction

   // Shift the first n entries down, insert the sample, average them.
   function automatic logic signed [DATA_W-1:0] predict_average(
      input logic signed [DATA_W-1:0] sample
   );
      int                       n;
      int                       sum;
      logic signed [DATA_W-1:0] average;
      n   = active_length();
      sum = 0;
      for (int k = 1; k < n; k++) window_store[k-1] = window_store[k];
      window_store[n-1] = sample;
      for (int k = 0; k < n; k++) sum += int'(window_store[k]);
      average = DATA_W'(sum / n);
      return average;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic signed [DATA_W-1:0] got,
                                  input logic signed [DATA_W-1:0] want);
      $display("%0t mismatch: %s, got %0d, expected %0d", $time, what, got, want);
      errors++;
   endtask

   always @(posedge clock) begin : monitor
      logic signed [DATA_W-1:0] want;
      if (reset) begin
         foreach (window_store[k]) window_store[k] = '0;
         length_reg = WINDOW_RESET;
         expected_averages.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_averages.size() == 0) begin
               report_mismatch("average word with none expected", rsp_average, '0);
            end else begin
               want = expected_averages.pop_front();
               if (rsp_average !== want) report_mismatch("average", rsp_average, want);
            end
         end
         if (req_valid && req_ready) expected_averages.push_back(predict_average(req_sample));
         if (csr_write_enable) length_reg = csr_write_data;
      end
      mismatch_count <= errors;
      outstanding    <= expected_averages.size();
   end

endmodule

// File: tb/tb_moving_average_filter.sv
module tb_moving_average_filter;
   import maf_pkg::*;

   logic             clock;
   logic             reset;
   logic             csr_write_enable;
   logic [CFG_W-1:0] csr_write_data;
   logic             quiet;
   logic             hold_off_request;
   int               mismatch_count;
   int               outstanding;

   maf_req_if req_ch ();
   maf_rsp_if rsp_ch ();

   moving_average_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   maf_average_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_ch.valid),
      .req_ready        (req_ch.ready),
      .req_sample       (req_ch.sample),
      .rsp_valid        (rsp_ch.valid),
      .rsp_ready        (rsp_ch.ready),
      .rsp_average      (rsp_ch.average),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Regression FAIL");
      $finish;
   end

   initial begin : rsp_side
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request && !hold_taken) begin
            hold_left  = 400;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ch.ready <= quiet || ($urandom_range(99) >= 27);
         end
      end
   end

   function automatic logic signed [DATA_W-1:0] random_sample();
      case ($urandom_range(9))
         0:       return 16'sh8000 + DATA_W'($urandom_range(3));
         1:       return 16'sh7FFF - DATA_W'($urandom_range(3));
         2, 3:    return DATA_W'(int'($urandom_range(16)) - 8);
         default: return DATA_W'($urandom);
      endcase
   endfunction

   task automatic send_sample(input logic signed [DATA_W-1:0] value);
      while (!quiet && $urandom_range(99) < 27) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.sample <= value;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (outstanding != 0 && waited < 20000);
   endtask

   // Hold the block idle before touching the length register.
   task automatic set_length(input logic [CFG_W-1:0] length);
      req_ch.valid <= 1'b0;
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= length;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      logic [CFG_W-1:0] lengths [10];
      lengths = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd5, 6'd33, 6'd8, 6'd17, 6'd2, 6'd8};
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.sample    <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= '0;
      quiet            <= 1'b0;
      hold_off_request <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // early words average with the cleared store; negatives truncate toward zero
      send_sample(-16'sd1);
      send_sample(-16'sd3);
      send_sample(16'sd5);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);

      set_length(6'd32);
      send_sample(16'sh8000);
      send_sample(16'sh8000);
      send_sample(16'sh7FFF);

      set_length(6'd1);
      send_sample(16'sh7FFF);
      send_sample(16'sh8000);
      send_sample(-16'sd7);

      set_length(6'd0);
      send_sample(-16'sd5);
      send_sample(16'sd12345);

      set_length(6'd63);
      send_sample(16'sd1);
      send_sample(-16'sd1);

      set_length(6'd3);
      send_sample(16'sh5555);
      send_sample(16'shAAAA);
      send_sample(-16'sd2);

      for (int p = 0; p < 10; p++) begin
         if (p == 6) set_length(CFG_W'($urandom_range(63)));
         else set_length(lengths[p]);
         quiet <= (p == 3 || p == 5);
         if (p == 5) hold_off_request <= 1'b1;
         repeat (70) send_sample(random_sample());
      end

      req_ch.valid <= 1'b0;
      drain();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
